// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL of the register run allocator.
// Each use states one clocked property, held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define RRA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition at one edge implies the consequent at the next edge.
`define RRA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rra_pkg.sv =====
// ----------------------------------------------------------------------------
// rra_pkg
// Types and codes shared by the register run allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rra_pkg;

    localparam int KIND_W   = 2;
    localparam int FIELD_W  = 8;
    localparam int STATUS_W = 2;
    // reg_in + run_length - 1 stays below 512
    localparam int CAND_W   = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET_ONE = 2'd0,
        KIND_PUT_ONE = 2'd1,
        KIND_GET_RUN = 2'd2,
        KIND_PUT_RUN = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_DUP       = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

    typedef struct packed {
        logic               vld;
        logic [FIELD_W-1:0] first;
        status_t            status;
    } rra_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rra_mem.sv =====
// ----------------------------------------------------------------------------
// rra_mem
// Free list storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rra_mem #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [AW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] wr_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rra_ctrl.sv =====
// ----------------------------------------------------------------------------
// rra_ctrl
// Sequencer: binary searches over the sorted free list, shifts entries up
// for an insert, and keeps the free count and the fresh mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rra_ctrl #(
    parameter int REG_COUNT = 256,
    localparam int AW = $clog2(REG_COUNT)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [rra_pkg::KIND_W-1:0]      in_kind,
    input  wire logic [rra_pkg::FIELD_W-1:0]     in_reg,
    input  wire logic [rra_pkg::FIELD_W-1:0]     in_len,
    output rra_pkg::rra_res_t                    res,
    input  wire logic                            res_ready,
    output logic                                 mem_rd_en,
    output logic      [AW-1:0]                   mem_rd_addr,
    input  wire logic [AW-1:0]                   mem_rd_data,
    output logic                                 mem_wr_en,
    output logic      [AW-1:0]                   mem_wr_addr,
    output logic      [AW-1:0]                   mem_wr_data
);

    import rra_pkg::*;

    localparam int CW = $clog2(REG_COUNT + 1);
    localparam int XW = (CW > 9) ? CW + 1 : 10;
    localparam logic [XW-1:0] REG_LIMIT = XW'(REG_COUNT);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_HI_RD    = 12'b0000_0000_0010,
        ST_HI_CHK   = 12'b0000_0000_0100,
        ST_RUN_RD   = 12'b0000_0000_1000,
        ST_RUN_CHK  = 12'b0000_0001_0000,
        ST_ALLOC    = 12'b0000_0010_0000,
        ST_RET_NEXT = 12'b0000_0100_0000,
        ST_POS_RD   = 12'b0000_1000_0000,
        ST_POS_CHK  = 12'b0001_0000_0000,
        ST_INS      = 12'b0010_0000_0000,
        ST_SH_RD    = 12'b0100_0000_0000,
        ST_SH_WR    = 12'b1000_0000_0000
    } state_t;

    // done state shares the idle-free encoding space: use a dedicated flag
    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       fresh_reg, fresh_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [AW-1:0]       top_reg, top_next;
    logic [CAND_W-1:0]   cand_reg, cand_next;
    logic [FIELD_W-1:0]  len_reg, len_next;
    logic                eq_reg, eq_next;
    logic                dup_reg, dup_next;
    logic [FIELD_W-1:0]  first_reg, first_next;
    status_t             status_reg, status_next;

    logic [CW:0]   run_mid;
    logic [CW:0]   pos_mid;
    logic [XW-1:0] x_rdata, x_cand, x_count, x_fresh, x_len, x_top, x_lo, x_mid, x_k;
    logic [XW-1:0] need_ext, need_new;
    logic          run_ok;

    always_comb begin
        x_rdata  = XW'(mem_rd_data);
        x_cand   = XW'(cand_reg);
        x_count  = XW'(count_reg);
        x_fresh  = XW'(fresh_reg);
        x_len    = XW'(len_reg);
        x_top    = XW'(top_reg);
        x_lo     = XW'(lo_reg);
        x_mid    = XW'(mid_reg);
        x_k      = XW'(k_reg);
        run_mid  = ({1'b0, lo_reg} + {1'b0, hi_reg} + (CW+1)'(1)) >> 1;
        pos_mid  = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
        // entries are distinct and ascending: a run of length mid ends at top
        // exactly when the entry mid-1 places below top is top-(mid-1)
        run_ok   = (x_rdata + x_mid - XW'(1)) == x_top;
        need_ext = x_fresh + x_len - x_lo;
        need_new = x_fresh + x_len;
    end

    always_comb begin
        state_next  = state_reg;
        done_next   = done_reg;
        count_next  = count_reg;
        fresh_next  = fresh_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        k_next      = k_reg;
        top_next    = top_reg;
        cand_next   = cand_reg;
        len_next    = len_reg;
        eq_next     = eq_reg;
        dup_next    = dup_reg;
        first_next  = first_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;

        if (done_reg) begin
            if (res_ready) begin
                done_next  = 1'b0;
                state_next = ST_IDLE;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    in_ready = 1'b1;
                    if (in_valid) begin
                        first_next  = '0;
                        status_next = STATUS_OK;
                        dup_next    = 1'b0;
                        cand_next   = CAND_W'(in_reg);
                        len_next    = in_len;
                        lo_next     = '0;
                        case (kind_t'(in_kind))
                            KIND_GET_ONE, KIND_GET_RUN: begin
                                if (kind_t'(in_kind) == KIND_GET_ONE) begin
                                    len_next = FIELD_W'(1);
                                end
                                if (kind_t'(in_kind) == KIND_GET_RUN && in_len == '0) begin
                                    done_next = 1'b1;
                                end else if (count_reg == '0) begin
                                    state_next = ST_ALLOC;
                                end else begin
                                    state_next = ST_HI_RD;
                                end
                            end
                            KIND_PUT_ONE: begin
                                len_next   = FIELD_W'(1);
                                state_next = ST_RET_NEXT;
                            end
                            KIND_PUT_RUN: begin
                                state_next = ST_RET_NEXT;
                            end
                            default: begin
                                done_next = 1'b1;
                            end
                        endcase
                    end
                end

                ST_HI_RD: begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(x_count - XW'(1));
                    state_next  = ST_HI_CHK;
                end

                ST_HI_CHK: begin
                    top_next = mem_rd_data;
                    lo_next  = CW'(1);
                    hi_next  = (x_len < x_count) ? CW'(len_reg) : count_reg;
                    if (hi_next == CW'(1)) begin
                        state_next = ST_ALLOC;
                    end else begin
                        state_next = ST_RUN_RD;
                    end
                end

                ST_RUN_RD: begin
                    mid_next    = run_mid[CW-1:0];
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(x_count - XW'(run_mid));
                    state_next  = ST_RUN_CHK;
                end

                ST_RUN_CHK: begin
                    if (run_ok) begin
                        lo_next = mid_reg;
                    end else begin
                        hi_next = mid_reg - CW'(1);
                    end
                    state_next = (lo_next == hi_next) ? ST_ALLOC : ST_RUN_RD;
                end

                ST_ALLOC: begin
                    done_next = 1'b1;
                    if (lo_reg != '0 && x_lo == x_len) begin
                        // whole request served from the top run
                        first_next = FIELD_W'(x_top + XW'(1) - x_len);
                        count_next = CW'(x_count - x_len);
                    end else if (lo_reg != '0 && (x_top + XW'(1)) == x_fresh) begin
                        // top run touches the fresh mark: extend it
                        if (need_ext > REG_LIMIT) begin
                            status_next = STATUS_EXHAUSTED;
                        end else begin
                            first_next = FIELD_W'(x_top + XW'(1) - x_lo);
                            count_next = CW'(x_count - x_lo);
                            fresh_next = CW'(need_ext);
                        end
                    end else if (need_new > REG_LIMIT) begin
                        status_next = STATUS_EXHAUSTED;
                    end else begin
                        first_next = FIELD_W'(x_fresh);
                        fresh_next = CW'(need_new);
                    end
                end

                ST_RET_NEXT: begin
                    if (len_reg == '0) begin
                        status_next = dup_reg ? STATUS_DUP : STATUS_OK;
                        done_next   = 1'b1;
                    end else if (x_cand >= REG_LIMIT) begin
                        cand_next = cand_reg + CAND_W'(1);
                        len_next  = len_reg - FIELD_W'(1);
                    end else begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        eq_next    = 1'b0;
                        state_next = (count_reg == '0) ? ST_INS : ST_POS_RD;
                    end
                end

                ST_POS_RD: begin
                    mid_next    = pos_mid[CW-1:0];
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(XW'(pos_mid));
                    state_next  = ST_POS_CHK;
                end

                ST_POS_CHK: begin
                    if (x_rdata < x_cand) begin
                        lo_next = mid_reg + CW'(1);
                    end else begin
                        hi_next = mid_reg;
                        eq_next = (x_rdata == x_cand);
                    end
                    state_next = (lo_next == hi_next) ? ST_INS : ST_POS_RD;
                end

                ST_INS: begin
                    if ((hi_reg != count_reg && eq_reg) || x_count >= REG_LIMIT) begin
                        // already free, or list full: skip this register
                        if (hi_reg != count_reg && eq_reg) begin
                            dup_next = 1'b1;
                        end
                        cand_next  = cand_reg + CAND_W'(1);
                        len_next   = len_reg - FIELD_W'(1);
                        state_next = ST_RET_NEXT;
                    end else begin
                        k_next     = count_reg;
                        state_next = ST_SH_RD;
                    end
                end

                ST_SH_RD: begin
                    if (k_reg == lo_reg) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(x_lo);
                        mem_wr_data = AW'(x_cand);
                        count_next  = count_reg + CW'(1);
                        cand_next   = cand_reg + CAND_W'(1);
                        len_next    = len_reg - FIELD_W'(1);
                        state_next  = ST_RET_NEXT;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(x_k - XW'(1));
                        state_next  = ST_SH_WR;
                    end
                end

                ST_SH_WR: begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(x_k);
                    mem_wr_data = mem_rd_data;
                    k_next      = k_reg - CW'(1);
                    state_next  = ST_SH_RD;
                end

                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            fresh_reg <= CW'(1);
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        k_reg      <= k_next;
        top_reg    <= top_next;
        cand_reg   <= cand_next;
        len_reg    <= len_next;
        eq_reg     <= eq_next;
        dup_reg    <= dup_next;
        first_reg  <= first_next;
        status_reg <= status_next;
    end

    always_comb begin
        res.vld    = done_reg;
        res.first  = first_reg;
        res.status = status_reg;
    end

    `RRA_ASSERT(a_wr_within_list, aclk, aresetn, !mem_wr_en || (XW'(mem_wr_addr) <= x_count), "free list write beyond fill count")
    `RRA_ASSERT(a_pos_range_open, aclk, aresetn, done_reg || state_reg != ST_POS_RD || lo_reg < hi_reg, "position search read with empty range")
    `RRA_ASSERT(a_state_bounds, aclk, aresetn, (x_count <= REG_LIMIT) && (fresh_reg != '0) && (x_fresh <= REG_LIMIT), "free count or fresh mark out of range")
    `RRA_ASSERT_NEXT(a_exhaust_keeps, aclk, aresetn, !done_reg && state_reg == ST_ALLOC && done_next && status_next == STATUS_EXHAUSTED, first_reg == '0 && $stable(count_reg) && $stable(fresh_reg), "exhausted request changed state")

endmodule

`default_nettype wire

// ===== rtl/core/register_run_allocator.sv =====
// ----------------------------------------------------------------------------
// register_run_allocator: register number allocator with sorted free list
// A get binary searches the top run over min(run, count); an empty list allocates directly
// and a zero-length run returns with no search. A return searches each register's slot, shifts
// entries up to insert it, skips a duplicate after its search and one beyond range. The
// next beat is taken in the cycle after the result reaches the output register.
// Reset: free list empty, fresh mark 1; list memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module register_run_allocator #(
    parameter int REG_COUNT = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rra_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [rra_pkg::FIELD_W-1:0]   s_reg_in,
    input  wire logic [rra_pkg::FIELD_W-1:0]   s_run_length,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rra_pkg::FIELD_W-1:0]   m_first_reg,
    output logic      [rra_pkg::STATUS_W-1:0]  m_status
);

    import rra_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    rra_res_t           res;
    logic               res_ready;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, rd_data, wr_addr, wr_data;

    logic               m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0] m_first_reg_reg;
    status_t            m_status_reg;

    rra_ctrl #(
        .REG_COUNT(REG_COUNT)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_kind    (s_kind),
        .in_reg     (s_reg_in),
        .in_len     (s_run_length),
        .res        (res),
        .res_ready  (res_ready),
        .mem_rd_en  (rd_en),
        .mem_rd_addr(rd_addr),
        .mem_rd_data(rd_data),
        .mem_wr_en  (wr_en),
        .mem_wr_addr(wr_addr),
        .mem_wr_data(wr_data)
    );

    rra_mem #(
        .DEPTH(REG_COUNT)
    ) u_mem (
        .aclk   (aclk),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    // output beat register
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res.vld && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.vld && res_ready) begin
            m_first_reg_reg <= res.first;
            m_status_reg    <= res.status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_first_reg = m_first_reg_reg;
    assign m_status    = m_status_reg;

endmodule

`default_nettype wire
